>>> sv/cfl_pkg.sv
// Shared types and constants for the core/forest/leaf decomposition unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package cfl_pkg;

  // Default node capacity and the fixed widths of the channel fields.
  localparam int MAX_NODES_DEF = 32;
  localparam int NODE_W        = 5;
  localparam int ADJ_OUT_W     = 32;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_NODE = 2'd1,
    OP_ADD_EDGE = 2'd2,
    OP_RUN      = 2'd3
  } op_t;

  // Node classification; KIND_NONE marks a node not yet classified.
  typedef enum logic [1:0] {
    KIND_CORE   = 2'd0,
    KIND_FOREST = 2'd1,
    KIND_LEAF   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_INIT  = 2'd1,
    ST_VISIT = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  // Input word.
  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [NODE_W-1:0]    node_index;
    kind_t                node_class;
    logic                 parent_valid;
    logic [NODE_W-1:0]    parent_index;
    logic [ADJ_OUT_W-1:0] core_adjacency;
    logic                 last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic visit;
    logic emit;
    logic first_pass;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic present;
    logic peel;
    logic out_free;
  } stat_t;

endpackage

>>> sv/cfl_datapath.sv
// Datapath of the decomposition unit: graph storage, the per-node visit logic
// and the result register. Depends on cfl_pkg; driven by cfl_ctrl commands.
module cfl_datapath #(
  parameter int  MAX_NODES = cfl_pkg::MAX_NODES_DEF,
  localparam int IDX_W     = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfl_pkg::in_word_t    in_data,
  input  cfl_pkg::cmd_t        cmd,
  input  logic [IDX_W-1:0]     idx,
  output cfl_pkg::stat_t       stat,
  output cfl_pkg::out_word_t   out_data,
  output logic                 out_valid,
  input  logic                 out_stall
);
  import cfl_pkg::*;

  logic [MAX_NODES-1:0] present_r, present_nxt;
  logic [MAX_NODES-1:0] loaded_r [MAX_NODES];
  logic [MAX_NODES-1:0] loaded_nxt [MAX_NODES];
  logic [MAX_NODES-1:0] work_r [MAX_NODES];
  logic [MAX_NODES-1:0] work_nxt [MAX_NODES];
  kind_t                kind_r [MAX_NODES];
  kind_t                kind_nxt [MAX_NODES];
  logic [IDX_W-1:0]     parent_r [MAX_NODES];
  logic [IDX_W-1:0]     parent_nxt [MAX_NODES];
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 a_ok, b_ok;
  logic [IDX_W-1:0]     a_idx, b_idx;
  logic [MAX_NODES-1:0] row;
  logic                 row_single;
  logic [IDX_W-1:0]     nbr;
  logic [MAX_NODES-1:0] higher;
  kind_t                emit_kind;
  logic                 emit_has_parent;

  // Range checks and index conversion of the input endpoints.
  assign a_ok  = int'(in_data.node_a) < MAX_NODES;
  assign b_ok  = int'(in_data.node_b) < MAX_NODES;
  assign a_idx = IDX_W'(in_data.node_a);
  assign b_idx = IDX_W'(in_data.node_b);

  // The row under visit and whether it holds exactly one neighbor.
  assign row        = work_r[idx];
  assign row_single = (row != '0) && ((row & (row - MAX_NODES'(1))) == '0);

  // Index of the single neighbor; the row is one-hot when it is used.
  always_comb begin
    nbr = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      if (row[k]) begin
        nbr = nbr | IDX_W'(k);
      end
    end
  end

  // Present nodes above the current index decide the last flag.
  assign higher = (present_r >> idx) >> 1;

  // Class as reported; a node left unclassified counts as core.
  assign emit_kind       = (kind_r[idx] == KIND_NONE) ? KIND_CORE : kind_r[idx];
  assign emit_has_parent = (emit_kind == KIND_FOREST) || (emit_kind == KIND_LEAF);

  // Next state of the graph store and the working copy.
  always_comb begin
    present_nxt = present_r;
    loaded_nxt  = loaded_r;
    work_nxt    = work_r;
    kind_nxt    = kind_r;
    parent_nxt  = parent_r;

    // Graph loading.
    if (cmd.load) begin
      unique case (in_data.op)
        OP_CLEAR: begin
          present_nxt = '0;
          for (int k = 0; k < MAX_NODES; k++) begin
            loaded_nxt[k] = '0;
          end
        end
        OP_ADD_NODE: begin
          if (a_ok) begin
            present_nxt[a_idx] = 1'b1;
          end
        end
        OP_ADD_EDGE: begin
          if (a_ok && b_ok && (a_idx != b_idx)) begin
            present_nxt[a_idx]        = 1'b1;
            present_nxt[b_idx]        = 1'b1;
            loaded_nxt[a_idx][b_idx]  = 1'b1;
            loaded_nxt[b_idx][a_idx]  = 1'b1;
          end
        end
        OP_RUN: begin
        end
      endcase
    end

    // Start of a run: fresh working copy, nothing classified.
    if (cmd.init) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        work_nxt[k] = present_r[k] ? loaded_r[k] : '0;
        kind_nxt[k] = KIND_NONE;
      end
    end

    // One node visit: peel a degree-one node, or mark an isolated one core.
    if (cmd.visit && present_r[idx]) begin
      if (row_single) begin
        kind_nxt[idx]      = cmd.first_pass ? KIND_LEAF : KIND_FOREST;
        parent_nxt[idx]    = nbr;
        work_nxt[idx]      = '0;
        work_nxt[nbr][idx] = 1'b0;
      end else if ((row == '0) && (kind_r[idx] == KIND_NONE)) begin
        kind_nxt[idx] = KIND_CORE;
      end
    end
  end

  // Result register: loads on emit, drains when the receiver takes it.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_nxt.node_index     = NODE_W'(idx);
      out_nxt.node_class     = emit_kind;
      out_nxt.parent_valid   = emit_has_parent;
      out_nxt.parent_index   = emit_has_parent ? NODE_W'(parent_r[idx]) : '0;
      out_nxt.core_adjacency = (emit_kind == KIND_CORE) ? ADJ_OUT_W'(row) : '0;
      out_nxt.last           = (higher == '0);
      out_valid_nxt          = 1'b1;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat          = '0;
    stat.present  = present_r[idx];
    stat.peel     = cmd.visit && present_r[idx] && row_single;
    stat.out_free = !out_valid_r || !out_stall;
  end

  // Control state and the loaded graph.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) begin
        loaded_r[k] <= '0;
      end
    end else begin
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      loaded_r    <= loaded_nxt;
    end
  end

  // Working state of a run and the result payload.
  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    kind_r   <= kind_nxt;
    parent_r <= parent_nxt;
    out_r    <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> sv/cfl_ctrl.sv
// Controller of the decomposition unit: sequences loading, the peeling
// passes and result emission. Depends on cfl_pkg; drives cfl_datapath.
module cfl_ctrl #(
  parameter int  MAX_NODES = cfl_pkg::MAX_NODES_DEF,
  localparam int IDX_W     = $clog2(MAX_NODES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cfl_pkg::op_t      in_op,
  output logic              in_stall,
  output cfl_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]  idx,
  input  cfl_pkg::stat_t    stat
);
  import cfl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             first_r, first_nxt;
  logic             peeled_r, peeled_nxt;

  // State register and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      first_r  <= 1'b1;
      peeled_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      peeled_r <= peeled_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    peeled_nxt = peeled_r;
    cmd        = '0;
    in_stall   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_RUN) begin
            state_nxt = ST_INIT;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end

      ST_INIT: begin
        cmd.init   = 1'b1;
        idx_nxt    = '0;
        first_nxt  = 1'b1;
        peeled_nxt = 1'b0;
        state_nxt  = ST_VISIT;
      end

      // One node per cycle; a pass that peels anything is followed by another.
      ST_VISIT: begin
        cmd.visit      = 1'b1;
        cmd.first_pass = first_r;
        if (idx_r == LAST_IDX) begin
          idx_nxt    = '0;
          peeled_nxt = 1'b0;
          if (peeled_r || stat.peel) begin
            first_nxt = 1'b0;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt    = idx_r + IDX_W'(1);
          peeled_nxt = peeled_r || stat.peel;
        end
      end

      // Absent nodes are skipped; present ones wait for a free result slot.
      ST_EMIT: begin
        if (!stat.present || stat.out_free) begin
          cmd.emit = stat.present;
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
    endcase
  end

  assign idx = idx_r;

endmodule

>>> sv/core_forest_leaf_decomposition_unit.sv
// Top level of the core/forest/leaf decomposition unit.
// Depends on cfl_pkg, cfl_ctrl and cfl_datapath.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one command
// word: clear the graph, add a node, add an undirected edge, or run. Load
// commands give no result. A run copies the loaded graph, peels it in passes
// over all MAX_NODES indices (one node visited per cycle by the controller's
// index counter), and then scans all MAX_NODES indices, one per cycle while
// no present node waits for a free result slot, sending one word per
// present node on the result channel (out_valid, out_stall, out_data) with
// last set on the final word. The number of passes is at most the number of
// present nodes plus one. in_stall stays high from the accepted run until
// the scan has passed the last index. A stall on the result channel holds
// the output word and pauses the scan; the next command can be accepted
// while the last word waits. Reset empties the graph and clears the result
// valid flag.
module core_forest_leaf_decomposition_unit #(
  parameter int MAX_NODES = cfl_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfl_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfl_pkg::out_word_t out_data
);
  import cfl_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] idx;

  // Sequencer.
  cfl_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .idx      (idx),
    .stat     (stat)
  );

  // Graph storage, visit logic and result register.
  cfl_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
